// ----- rtl/bpf_pkg.sv -----
`default_nettype none
package bpf_pkg;

    typedef enum logic [2:0] {
        OP_MOVE  = 3'd0,
        OP_LINE  = 3'd1,
        OP_CURVE = 3'd2,
        OP_CURVV = 3'd3,
        OP_CURVY = 3'd4,
        OP_RECT  = 3'd5
    } opcode_t;

    localparam logic [15:0] STEP_RESET = 16'd3277;

    // Fraction bits of the curve parameter; the 16-bit step field fixes it.
    localparam int FRAC_BITS = 16;

    // Command handed from the front end to the back end.
    typedef struct packed {
        opcode_t            op;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               start;
        logic               last;
    } point_t;

endpackage
`default_nettype wire

// ----- rtl/bezier_path_flattener_unit.sv -----
`default_nettype none
// Path flattener: takes move, line, cubic curve (full, v and y forms) and
// rectangle commands and emits polyline points. A front queue takes commands
// and drops unknown opcodes; the back end works on one command at a time.
// Move and line give one point, a rectangle four. A curve computes each
// point in steps (six weight products through a single shared multiplier,
// four blend steps, rounding), then gives its exact end point, so up to
// MAX_POINTS points in all.
// A point waiting on the output holds the back end until it is taken.
module bezier_path_flattener_unit #(
    parameter int MAX_POINTS = 64
) (
    input  wire  logic          clk,
    input  wire  logic          rst_n,
    input  wire  logic          cfg_valid,
    output logic                cfg_ready,
    input  wire  logic [15:0]   cfg_data,
    input  wire  logic          s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire  logic [191:0]  s_axis_tdata,  // ax, ay, bx, by, end_x, end_y
    input  wire  logic [2:0]    s_axis_tuser,  // opcode
    output logic                m_axis_tvalid,
    input  wire  logic          m_axis_tready,
    output logic [63:0]         m_axis_tdata,  // point_x, point_y
    output logic                m_axis_tlast,  // last_point
    output logic                m_axis_tuser   // subpath_start
);
    logic [15:0]      step_reg;
    bpf_pkg::cmd_t    in_cmd, q_cmd;
    logic             q_valid, q_ready;
    bpf_pkg::point_t  pt;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= bpf_pkg::STEP_RESET;
        end
        else if (cfg_valid)
        begin
            step_reg <= cfg_data;
        end
    end

    assign in_cmd.op = bpf_pkg::opcode_t'(s_axis_tuser);
    assign in_cmd.ax = s_axis_tdata[31:0];
    assign in_cmd.ay = s_axis_tdata[63:32];
    assign in_cmd.bx = s_axis_tdata[95:64];
    assign in_cmd.by = s_axis_tdata[127:96];
    assign in_cmd.ex = s_axis_tdata[159:128];
    assign in_cmd.ey = s_axis_tdata[191:160];

    bpf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (in_cmd),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd)
    );

    bpf_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_size (step_reg),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_pt    (pt)
    );

    assign m_axis_tdata = {pt.y, pt.x};
    assign m_axis_tlast = pt.last;
    assign m_axis_tuser = pt.start;
endmodule
`default_nettype wire

// ----- rtl/bpf_front.sv -----
`default_nettype none
module bpf_front #(
    parameter int QDEPTH = 2
) (
    input  wire  logic           clk,
    input  wire  logic           rst_n,
    input  wire  logic           in_valid,
    output logic                 in_ready,
    input  wire  bpf_pkg::cmd_t  in_cmd,
    output logic                 cmd_valid,
    input  wire  logic           cmd_ready,
    output bpf_pkg::cmd_t        cmd
);
    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    bpf_pkg::cmd_t  mem_reg [QDEPTH];
    logic [AW-1:0]  wp_reg, rp_reg;
    logic [AW:0]    cnt_reg;
    logic           push, pop, legal;

    // Unknown opcodes are dropped here and never reach the back end.
    assign legal     = (in_cmd.op inside {bpf_pkg::OP_MOVE, bpf_pkg::OP_LINE,
                        bpf_pkg::OP_CURVE, bpf_pkg::OP_CURVV, bpf_pkg::OP_CURVY,
                        bpf_pkg::OP_RECT});
    assign in_ready  = (cnt_reg != (AW+1)'(QDEPTH));
    assign push      = in_valid && in_ready && legal;
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == AW'(QDEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == AW'(QDEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

// ----- rtl/bpf_back.sv -----
`default_nettype none
module bpf_back #(
    parameter int MAX_POINTS = 64
) (
    input  wire  logic           clk,
    input  wire  logic           rst_n,
    input  wire  logic [15:0]    step_size,
    input  wire  logic           cmd_valid,
    output logic                 cmd_ready,
    input  wire  bpf_pkg::cmd_t  cmd,
    output logic                 out_valid,
    input  wire  logic           out_ready,
    output bpf_pkg::point_t      out_pt
);
    localparam int NW = $clog2(MAX_POINTS) + 1;
    localparam logic [16:0] ONE  = 17'(1) << bpf_pkg::FRAC_BITS;
    localparam logic [33:0] HALF = 34'(1) << (bpf_pkg::FRAC_BITS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RECT, S_UU, S_TT, S_W0, S_W1, S_W2, S_W3,
        S_BLEND, S_ROUND, S_EMIT, S_END
    } state_t;

    state_t             state_reg;
    logic [2:0]         corner_reg;
    logic signed [31:0] cx_reg, cy_reg;
    logic signed [31:0] p1x_reg, p1y_reg, p2x_reg, p2y_reg, p3x_reg, p3y_reg;
    logic signed [31:0] rx_reg, ty_reg;
    logic [16:0]        dt_reg, t_reg, u_reg;
    logic [17:0]        uu_reg, tt_reg;
    logic [17:0]        w0_reg, w1_reg, w2_reg, w3_reg;
    logic [2:0]         bi_reg;
    logic signed [65:0] accx_reg, accy_reg;
    logic [NW-1:0]      n_reg;
    bpf_pkg::point_t    pt_reg;
    logic               ov_reg;
    logic               mv_reg;

    logic [35:0]        ma, mb, mp;
    logic [17:0]        mr;
    logic [17:0]        bw;
    logic signed [31:0] bpx, bpy;
    logic signed [65:0] rxs, rys;

    // One shared multiplier for the weight products.
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            S_UU:    begin ma = 36'(u_reg);  mb = 36'(u_reg); end
            S_TT:    begin ma = 36'(t_reg);  mb = 36'(t_reg); end
            S_W0:    begin ma = 36'(uu_reg); mb = 36'(u_reg); end
            S_W1:    begin ma = 36'(uu_reg); mb = 36'(t_reg); end
            S_W2:    begin ma = 36'(tt_reg); mb = 36'(u_reg); end
            S_W3:    begin ma = 36'(tt_reg); mb = 36'(t_reg); end
            default: begin ma = '0; mb = '0; end
        endcase
        mp = ma * mb;
        mr = 18'((mp + 36'(HALF)) >> bpf_pkg::FRAC_BITS);
    end

    always_comb
    begin
        case (bi_reg)
            3'd0:    begin bw = w0_reg; bpx = cx_reg;  bpy = cy_reg;  end
            3'd1:    begin bw = w1_reg; bpx = p1x_reg; bpy = p1y_reg; end
            3'd2:    begin bw = w2_reg; bpx = p2x_reg; bpy = p2y_reg; end
            default: begin bw = w3_reg; bpx = p3x_reg; bpy = p3y_reg; end
        endcase
        rxs = (accx_reg + 66'(HALF)) >>> bpf_pkg::FRAC_BITS;
        rys = (accy_reg + 66'(HALF)) >>> bpf_pkg::FRAC_BITS;
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign out_pt    = pt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cx_reg     <= '0;
            cy_reg     <= '0;
            ov_reg     <= 1'b0;
            corner_reg <= '0;
        end
        else
        begin
            if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        p1x_reg <= cmd.ax;
                        p1y_reg <= cmd.ay;
                        p2x_reg <= cmd.bx;
                        p2y_reg <= cmd.by;
                        p3x_reg <= cmd.ex;
                        p3y_reg <= cmd.ey;
                        rx_reg  <= cmd.ax + cmd.bx;
                        ty_reg  <= cmd.ay + cmd.by;
                        dt_reg  <= (step_size == 16'd0) ? 17'd1 : 17'(step_size);
                        t_reg   <= (step_size == 16'd0) ? 17'd1 : 17'(step_size);
                        u_reg   <= ONE - ((step_size == 16'd0) ? 17'd1 : 17'(step_size));
                        n_reg   <= '0;
                        case (cmd.op)
                            bpf_pkg::OP_MOVE, bpf_pkg::OP_LINE:
                            begin
                                mv_reg    <= (cmd.op == bpf_pkg::OP_MOVE);
                                cx_reg    <= cmd.ax;
                                cy_reg    <= cmd.ay;
                                state_reg <= S_EMIT;
                            end
                            bpf_pkg::OP_RECT:
                            begin
                                corner_reg <= '0;
                                state_reg  <= S_RECT;
                            end
                            default:
                            begin
                                if (cmd.op == bpf_pkg::OP_CURVV)
                                begin
                                    p1x_reg <= cx_reg;
                                    p1y_reg <= cy_reg;
                                end
                                else if (cmd.op == bpf_pkg::OP_CURVY)
                                begin
                                    p2x_reg <= cmd.ex;
                                    p2y_reg <= cmd.ey;
                                end
                                state_reg <= S_UU;
                            end
                        endcase
                    end
                end
                S_RECT:
                begin
                    if (!ov_reg || out_ready)
                    begin
                        ov_reg <= 1'b1;
                        case (corner_reg)
                            3'd0:    pt_reg <= '{p1x_reg, p1y_reg, 1'b1, 1'b0};
                            3'd1:    pt_reg <= '{rx_reg,  p1y_reg, 1'b0, 1'b0};
                            3'd2:    pt_reg <= '{rx_reg,  ty_reg,  1'b0, 1'b0};
                            default: pt_reg <= '{p1x_reg, ty_reg,  1'b0, 1'b1};
                        endcase
                        corner_reg <= corner_reg + 3'd1;
                        if (corner_reg == 3'd3)
                        begin
                            cx_reg    <= p1x_reg;
                            cy_reg    <= ty_reg;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_UU:
                begin
                    if (t_reg >= ONE || n_reg == NW'(MAX_POINTS - 1))
                    begin
                        state_reg <= S_END;
                    end
                    else
                    begin
                        uu_reg    <= mr;
                        state_reg <= S_TT;
                    end
                end
                S_TT: begin tt_reg <= mr; state_reg <= S_W0; end
                S_W0: begin w0_reg <= mr; state_reg <= S_W1; end
                S_W1: begin w1_reg <= 18'(3 * mr); state_reg <= S_W2; end
                S_W2: begin w2_reg <= 18'(3 * mr); state_reg <= S_W3; end
                S_W3:
                begin
                    w3_reg    <= mr;
                    bi_reg    <= '0;
                    accx_reg  <= '0;
                    accy_reg  <= '0;
                    state_reg <= S_BLEND;
                end
                // One weight-point pair per cycle, both coordinates together.
                S_BLEND:
                begin
                    accx_reg <= accx_reg + $signed({1'b0, bw}) * 66'(bpx);
                    accy_reg <= accy_reg + $signed({1'b0, bw}) * 66'(bpy);
                    bi_reg   <= bi_reg + 3'd1;
                    if (bi_reg == 3'd3)
                    begin
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    if (!ov_reg || out_ready)
                    begin
                        ov_reg    <= 1'b1;
                        pt_reg    <= '{rxs[31:0], rys[31:0], 1'b0, 1'b0};
                        n_reg     <= n_reg + 1'b1;
                        t_reg     <= t_reg + dt_reg;
                        u_reg     <= u_reg - dt_reg;
                        state_reg <= S_UU;
                    end
                end
                S_END:
                begin
                    if (!ov_reg || out_ready)
                    begin
                        ov_reg    <= 1'b1;
                        pt_reg    <= '{p3x_reg, p3y_reg, 1'b0, 1'b1};
                        cx_reg    <= p3x_reg;
                        cy_reg    <= p3y_reg;
                        state_reg <= S_IDLE;
                    end
                end
                S_EMIT:
                begin
                    if (!ov_reg || out_ready)
                    begin
                        ov_reg    <= 1'b1;
                        pt_reg    <= '{p1x_reg, p1y_reg, mv_reg, 1'b1};
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
